FILE: sv/ssl_pkg.sv
package ssl_pkg;

  localparam int DEF_MAX_SPANS = 256;

  // Q1.16 value of 1.0
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // control that travels with a query
  typedef struct packed {
    logic vld;
    logic nonempty;
  } ssl_ctl_t;

  // table write broadcast to every table copy
  typedef struct packed {
    logic        we;
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] scale;
  } ssl_wr_t;

endpackage

FILE: sv/ssl_map.sv
module ssl_map
  import ssl_pkg::*;
#(
  parameter int MAX_SPANS = DEF_MAX_SPANS,
  localparam int IW = $clog2(MAX_SPANS),
  localparam int CW = $clog2(MAX_SPANS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ssl_ctl_t             ctl_in,
  input  logic [16:0]          t_in,
  input  logic [CW-1:0]        n_in,
  input  ssl_wr_t              wr,
  input  logic [IW-1:0]        wr_addr,
  output ssl_ctl_t             ctl_out,
  output logic signed [34:0]   s_out,
  output logic [IW-1:0]        hi_out
);

  logic [31:0]        lower0_r;
  logic [31:0]        upper_mem [MAX_SPANS];
  logic [IW-1:0]      last_addr;

  ssl_ctl_t           c1_r, c2_r, c3_r, c4_r;
  logic [16:0]        t1_r, t2_r;
  logic signed [31:0] first1_r, first2_r, first3_r;
  logic signed [31:0] last1_r;
  logic [IW-1:0]      hi1_r, hi2_r, hi3_r, hi4_r;
  logic signed [32:0] diff2_r, diff2_nxt;
  logic signed [50:0] prod3_r, prod3_nxt;
  logic signed [34:0] s4_r, s4_nxt;

  assign last_addr = IW'(n_in - CW'(1));

  // hold span 0 lower bound, write the upper bound copy
  always_ff @(posedge clk) begin
    if (wr.we && wr_addr == '0) begin
      lower0_r <= wr.lower;
    end
    if (wr.we) begin
      upper_mem[wr_addr] <= wr.upper;
    end
    if (en) begin
      last1_r <= upper_mem[last_addr];
    end
  end

  assign diff2_nxt = 33'(last1_r) - 33'(first1_r);
  assign prod3_nxt = $signed({34'd0, t2_r}) * 51'(diff2_r);
  assign s4_nxt    = 35'(first3_r) + prod3_r[50:16];

  // advance the mapping stages
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= t_in;
      first1_r <= $signed(lower0_r);
      hi1_r    <= last_addr;
      t2_r     <= t1_r;
      first2_r <= first1_r;
      hi2_r    <= hi1_r;
      diff2_r  <= diff2_nxt;
      first3_r <= first2_r;
      hi3_r    <= hi2_r;
      prod3_r  <= prod3_nxt;
      hi4_r    <= hi3_r;
      s4_r     <= s4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else if (en) begin
      c1_r <= ctl_in;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  assign ctl_out = c4_r;
  assign s_out   = s4_r;
  assign hi_out  = hi4_r;

endmodule

FILE: sv/ssl_level.sv
module ssl_level
  import ssl_pkg::*;
#(
  parameter int MAX_SPANS = DEF_MAX_SPANS,
  localparam int IW = $clog2(MAX_SPANS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ssl_ctl_t             ctl_in,
  input  logic signed [34:0]   s_in,
  input  logic [IW-1:0]        lo_in,
  input  logic [IW-1:0]        hi_in,
  input  ssl_wr_t              wr,
  input  logic [IW-1:0]        wr_addr,
  output ssl_ctl_t             ctl_out,
  output logic signed [34:0]   s_out,
  output logic [IW-1:0]        lo_out,
  output logic [IW-1:0]        hi_out
);

  logic [31:0]        upper_mem [MAX_SPANS];
  logic [IW-1:0]      chk_nxt;
  ssl_ctl_t           c_r;
  logic signed [34:0] s_r;
  logic [IW-1:0]      lo_r, hi_r, chk_r;
  logic signed [31:0] ub_r;

  assign chk_nxt = IW'(({1'b0, lo_in} + {1'b0, hi_in}) >> 1);

  // own copy of the upper bounds, read at the midpoint
  always_ff @(posedge clk) begin
    if (wr.we) begin
      upper_mem[wr_addr] <= wr.upper;
    end
    if (en) begin
      ub_r  <= $signed(upper_mem[chk_nxt]);
      s_r   <= s_in;
      lo_r  <= lo_in;
      hi_r  <= hi_in;
      chk_r <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
    end else if (en) begin
      c_r <= ctl_in;
    end
  end

  // narrow the range by the midpoint compare
  always_comb begin
    lo_out = lo_r;
    hi_out = hi_r;
    if (lo_r < hi_r) begin
      if (s_r >= 35'(ub_r)) begin
        lo_out = IW'(chk_r + 1'b1);
      end else begin
        hi_out = chk_r;
      end
    end
  end

  assign ctl_out = c_r;
  assign s_out   = s_r;

endmodule

FILE: sv/ssl_local.sv
module ssl_local
  import ssl_pkg::*;
#(
  parameter int MAX_SPANS = DEF_MAX_SPANS,
  localparam int IW = $clog2(MAX_SPANS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ssl_ctl_t             ctl_in,
  input  logic signed [34:0]   s_in,
  input  logic [IW-1:0]        lo_in,
  input  ssl_wr_t              wr,
  input  logic [IW-1:0]        wr_addr,
  output logic                 out_valid,
  output logic                 found,
  output logic [7:0]           span_index,
  output logic [16:0]          local_t
);

  logic [31:0]        lower_mem [MAX_SPANS];
  logic [31:0]        scale_mem [MAX_SPANS];

  ssl_ctl_t           c1_r, c2_r, c3_r;
  logic signed [34:0] s1_r;
  logic [IW-1:0]      lo1_r, lo2_r, lo3_r;
  logic signed [31:0] lb1_r;
  logic [31:0]        sc1_r, sc2_r;
  logic signed [35:0] diff2_r, diff2_nxt;
  logic               zero3_r, sat3_r;
  logic [63:0]        prod3_r;
  logic [47:0]        scaled;
  logic [16:0]        local_nxt;
  logic               valid_r, found_r;
  logic [7:0]         index_r;
  logic [16:0]        local_r;

  // read lower bound and scale of the chosen span
  always_ff @(posedge clk) begin
    if (wr.we) begin
      lower_mem[wr_addr] <= wr.lower;
      scale_mem[wr_addr] <= wr.scale;
    end
    if (en) begin
      lb1_r <= $signed(lower_mem[lo_in]);
      sc1_r <= scale_mem[lo_in];
    end
  end

  assign diff2_nxt = 36'(s1_r) - 36'(lb1_r);

  // advance offset and product stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= s_in;
      lo1_r   <= lo_in;
      diff2_r <= diff2_nxt;
      sc2_r   <= sc1_r;
      lo2_r   <= lo1_r;
      zero3_r <= (diff2_r <= 36'sd0) || (sc2_r == '0);
      sat3_r  <= !diff2_r[35] && (diff2_r[34:32] != '0);
      prod3_r <= 64'(diff2_r[31:0]) * 64'(sc2_r);
      lo3_r   <= lo2_r;
    end
  end

  // clamp the local parameter to 0..1.0
  assign scaled = prod3_r[63:16];
  always_comb begin
    if (!c3_r.nonempty || zero3_r) begin
      local_nxt = '0;
    end else if (sat3_r || scaled > 48'(ONE_Q16)) begin
      local_nxt = ONE_Q16;
    end else begin
      local_nxt = scaled[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found_r <= c3_r.nonempty;
      index_r <= c3_r.nonempty ? 8'(lo3_r) : 8'd0;
      local_r <= local_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      c1_r    <= ctl_in;
      c2_r    <= c1_r;
      c3_r    <= c2_r;
      valid_r <= c3_r.vld;
    end
  end

  assign out_valid  = valid_r;
  assign found      = found_r;
  assign span_index = index_r;
  assign local_t    = local_r;

endmodule

FILE: sv/spline_span_locator.sv
// Spline span locator.
// Input channel (in_valid / in_stall): action 0 loads one span entry
// (lower, upper, scale) at in_entry_index; a load at or beyond the span
// count is dropped. Action 1 queries in_param_t and produces one result.
// Result channel (out_valid / out_stall): found, span index and local t.
// cfg_wr_en / cfg_wr_data set the span count; write it only while idle.
// Four mapping stages, one stage per search level (LEVELS =
// clog2(MAX_SPANS) levels), four stages for the local parameter.
// Throughput: one query per cycle while out_stall does not hold the pipeline. Each search level owns a copy of the
// upper bound table, so every level reads its own port each cycle.
// A load is held off until no query is in flight.
// Reset clears all valid bits and the span count; table contents stay
// undefined until loaded. When out_stall is high while a result waits,
// the whole pipeline holds and in_stall rises, so no item is lost or
// repeated.
module spline_span_locator
  import ssl_pkg::*;
#(
  parameter int MAX_SPANS = DEF_MAX_SPANS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [8:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [7:0]          in_entry_index,
  input  logic signed [31:0]  in_span_lower,
  input  logic signed [31:0]  in_span_upper,
  input  logic [31:0]         in_span_scale,
  input  logic [16:0]         in_param_t,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [7:0]          out_span_index,
  output logic [16:0]         out_local_t
);

  localparam int IW     = $clog2(MAX_SPANS);
  localparam int CW     = $clog2(MAX_SPANS + 1);
  localparam int LEVELS = IW;
  localparam int DEPTH  = LEVELS + 8;
  localparam int NW     = $clog2(DEPTH + 2);

  logic [8:0]         spans_r;
  logic [CW-1:0]      n_eff;
  logic               en, busy, in_acc, q_acc, out_acc;
  logic [NW-1:0]      inflight_r;
  logic [16:0]        t_sat;
  ssl_wr_t            wr;
  logic [IW-1:0]      wr_addr;
  ssl_ctl_t           q_ctl;

  ssl_ctl_t           lvl_ctl [LEVELS+1];
  logic signed [34:0] lvl_s   [LEVELS+1];
  logic [IW-1:0]      lvl_lo  [LEVELS+1];
  logic [IW-1:0]      lvl_hi  [LEVELS+1];

  // span count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spans_r <= '0;
    end else if (cfg_wr_en) begin
      spans_r <= cfg_wr_data;
    end
  end

  assign n_eff = (32'(spans_r) > 32'(MAX_SPANS)) ? CW'(MAX_SPANS) : CW'(spans_r);

  // handshake: hold everything on output stall, hold loads while busy
  assign en       = !(out_valid && out_stall);
  assign busy     = (inflight_r != '0);
  assign in_stall = !en || (in_action == ACT_LOAD && busy);
  assign in_acc   = in_valid && !in_stall;
  assign q_acc    = in_acc && in_action == ACT_QUERY;
  assign out_acc  = out_valid && !out_stall;

  // count queries in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (q_acc && !out_acc) begin
      inflight_r <= NW'(inflight_r + 1'b1);
    end else if (out_acc && !q_acc) begin
      inflight_r <= NW'(inflight_r - 1'b1);
    end
  end

  // table write broadcast
  assign wr_addr  = IW'(in_entry_index);
  assign wr.we    = in_acc && in_action == ACT_LOAD && (32'(in_entry_index) < 32'(n_eff));
  assign wr.lower = in_span_lower;
  assign wr.upper = in_span_upper;
  assign wr.scale = in_span_scale;

  assign t_sat          = (in_param_t > ONE_Q16) ? ONE_Q16 : in_param_t;
  assign q_ctl.vld      = q_acc;
  assign q_ctl.nonempty = (n_eff != '0);

  ssl_map #(.MAX_SPANS(MAX_SPANS)) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (q_ctl),
    .t_in    (t_sat),
    .n_in    (n_eff),
    .wr      (wr),
    .wr_addr (wr_addr),
    .ctl_out (lvl_ctl[0]),
    .s_out   (lvl_s[0]),
    .hi_out  (lvl_hi[0])
  );

  assign lvl_lo[0] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    ssl_level #(.MAX_SPANS(MAX_SPANS)) u_level (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (lvl_ctl[g]),
      .s_in    (lvl_s[g]),
      .lo_in   (lvl_lo[g]),
      .hi_in   (lvl_hi[g]),
      .wr      (wr),
      .wr_addr (wr_addr),
      .ctl_out (lvl_ctl[g+1]),
      .s_out   (lvl_s[g+1]),
      .lo_out  (lvl_lo[g+1]),
      .hi_out  (lvl_hi[g+1])
    );
  end

  ssl_local #(.MAX_SPANS(MAX_SPANS)) u_local (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl_in     (lvl_ctl[LEVELS]),
    .s_in       (lvl_s[LEVELS]),
    .lo_in      (lvl_lo[LEVELS]),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .out_valid  (out_valid),
    .found      (out_found),
    .span_index (out_span_index),
    .local_t    (out_local_t)
  );

  // a load only enters an empty pipeline
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action == ACT_LOAD) |-> !busy)
    else $error("load accepted with queries in flight");

  // an empty-table result carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_span_index == 8'd0 && out_local_t == '0))
    else $error("empty-table result has nonzero fields");

  // local parameter stays within 0..1.0
  a_local_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_local_t <= ONE_Q16))
    else $error("local parameter out of range");

  // no result without a query in flight
  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result without a query in flight");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
